/* rtl/core/tas_pkg.sv */
// Shared widths, constants and the result type of the tournament arena.
package tas_pkg;

   localparam int IndexW = 10;
   localparam int FitInW = 16;
   localparam int CountW = 8;
   localparam int NumSlots = 4;

   // Indices at or above this bound are rejected.
   localparam int POPULATION_SIZE = 1024;
   localparam int FITNESS_BITS_DEF = 16;

   localparam logic [CountW-1:0] RoundsMin = CountW'(4);
   localparam logic [CountW-1:0] RoundsReset = CountW'(4);

   typedef struct packed {
      logic              accepted;
      logic              done_res;
      logic [IndexW-1:0] parent_a_index;
      logic [IndexW-1:0] parent_b_index;
      logic [IndexW-1:0] child_a_index;
      logic [IndexW-1:0] child_b_index;
   } tas_result_type;

endpackage

/* rtl/core/tas_arena.sv */
// Slot registers, duplicate check, ranking update and round counter.
module tas_arena #(
   parameter int FITNESS_BITS = tas_pkg::FITNESS_BITS_DEF
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          fire,
   input  logic [tas_pkg::IndexW-1:0]    idx,
   input  logic [tas_pkg::FitInW-1:0]    fitness,
   input  logic [tas_pkg::CountW-1:0]    rounds,
   output tas_pkg::tas_result_type       result
);
   import tas_pkg::*;

   localparam int FitW = (FITNESS_BITS < FitInW) ? FITNESS_BITS : FitInW;
   localparam int PopW = 17;
   localparam int SlotPa = 0;
   localparam int SlotPb = 1;
   localparam int SlotCa = 2;
   localparam int SlotCb = 3;

   logic [IndexW-1:0]   slot_index_ff [NumSlots];
   logic [IndexW-1:0]   slot_index_in [NumSlots];
   logic [FitW-1:0]     slot_fit_ff [NumSlots];
   logic [FitW-1:0]     slot_fit_in [NumSlots];
   logic [NumSlots-1:0] filled_ff;
   logic [NumSlots-1:0] filled_in;
   logic [CountW-1:0]   count_ff;
   logic [CountW-1:0]   count_in;

   logic [FitW-1:0]     fit;
   logic                dup;
   logic                out_of_range;
   logic                take;
   logic [CountW-1:0]   count_inc;
   logic [CountW-1:0]   limit;
   logic                done;

   always_comb begin
      fit = fitness[FitW-1:0];
      dup = 1'b0;
      for (int s = 0; s < NumSlots; s++) begin
         if (filled_ff[s] && (slot_index_ff[s] == idx)) begin
            dup = 1'b1;
         end
      end
      out_of_range = PopW'(idx) >= PopW'(POPULATION_SIZE);
      take = fire && !dup && !out_of_range;

      for (int s = 0; s < NumSlots; s++) begin
         slot_index_in[s] = slot_index_ff[s];
         slot_fit_in[s] = slot_fit_ff[s];
      end
      filled_in = filled_ff;
      count_in = count_ff;

      count_inc = count_ff + 1'b1;
      limit = (rounds < RoundsMin) ? RoundsMin : rounds;
      done = take && (count_inc >= limit);

      if (take) begin
         // Empty slots fill in order; once full, the ranking rules apply.
         if (!filled_ff[SlotPa]) begin
            slot_index_in[SlotPa] = idx;
            slot_fit_in[SlotPa] = fit;
            filled_in[SlotPa] = 1'b1;
         end else if (!filled_ff[SlotPb]) begin
            slot_index_in[SlotPb] = idx;
            slot_fit_in[SlotPb] = fit;
            filled_in[SlotPb] = 1'b1;
         end else if (!filled_ff[SlotCa]) begin
            slot_index_in[SlotCa] = idx;
            slot_fit_in[SlotCa] = fit;
            filled_in[SlotCa] = 1'b1;
         end else if (!filled_ff[SlotCb]) begin
            slot_index_in[SlotCb] = idx;
            slot_fit_in[SlotCb] = fit;
            filled_in[SlotCb] = 1'b1;
         end else if (fit > slot_fit_ff[SlotPa]) begin
            slot_index_in[SlotPb] = slot_index_ff[SlotPa];
            slot_fit_in[SlotPb] = slot_fit_ff[SlotPa];
            slot_index_in[SlotPa] = idx;
            slot_fit_in[SlotPa] = fit;
         end else if (fit > slot_fit_ff[SlotPb]) begin
            slot_index_in[SlotPb] = idx;
            slot_fit_in[SlotPb] = fit;
         end else if (fit < slot_fit_ff[SlotCb]) begin
            slot_index_in[SlotCa] = slot_index_ff[SlotCb];
            slot_fit_in[SlotCa] = slot_fit_ff[SlotCb];
            slot_index_in[SlotCb] = idx;
            slot_fit_in[SlotCb] = fit;
         end else if (fit < slot_fit_ff[SlotCa]) begin
            slot_index_in[SlotCa] = idx;
            slot_fit_in[SlotCa] = fit;
         end

         if (done) begin
            count_in = '0;
            filled_in = '0;
         end else begin
            count_in = count_inc;
         end
      end

      result.accepted = take;
      result.done_res = done;
      result.parent_a_index = done ? slot_index_in[SlotPa] : '0;
      result.parent_b_index = done ? slot_index_in[SlotPb] : '0;
      result.child_a_index = done ? slot_index_in[SlotCa] : '0;
      result.child_b_index = done ? slot_index_in[SlotCb] : '0;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         filled_ff <= '0;
         count_ff <= '0;
      end else begin
         filled_ff <= filled_in;
         count_ff <= count_in;
      end
   end

   // Index and fitness need no reset; the filled bits gate every use.
   always_ff @(posedge clock) begin
      for (int s = 0; s < NumSlots; s++) begin
         slot_index_ff[s] <= slot_index_in[s];
         slot_fit_ff[s] <= slot_fit_in[s];
      end
   end

   a_done_needs_accept: assert property (@(posedge clock) disable iff (reset)
      result.done_res |-> result.accepted)
      else $error("selection emitted for a rejected contestant");

   a_done_clears: assert property (@(posedge clock) disable iff (reset)
      (fire && result.done_res) |=> (count_ff == '0 && filled_ff == '0))
      else $error("arena not cleared after a selection");

   a_fill_prefix: assert property (@(posedge clock) disable iff (reset)
      (filled_ff == 4'b0000 || filled_ff == 4'b0001 || filled_ff == 4'b0011 ||
       filled_ff == 4'b0111 || filled_ff == 4'b1111))
      else $error("slots filled out of order");

   a_distinct_on_done: assert property (@(posedge clock) disable iff (reset)
      (fire && result.done_res) |->
         (result.parent_a_index != result.parent_b_index &&
          result.parent_a_index != result.child_a_index &&
          result.parent_a_index != result.child_b_index &&
          result.parent_b_index != result.child_a_index &&
          result.parent_b_index != result.child_b_index &&
          result.child_a_index != result.child_b_index))
      else $error("duplicate index in emitted selection");

endmodule

/* rtl/core/tournament_arena_select.sv */
// Top level of the four-slot tournament arena: request stage, arena and response stage.
// The arena takes one request per clock cycle while req_stall is low and answers every
// request with one response, registered in the request stage and then in the output
// register. The slot registers are read and rewritten in the same cycle, so each request
// sees the arena as the previous request left it. A response waiting in the output
// register does not block the request stage from holding the next request.
// The user writes tournament_rounds through csr_wr_en and csr_wr_data only while no
// request is in flight; the block does not check it. Values below four act as four. A
// response with done_res set carries the four selected indices and clears the arena.
module tournament_arena_select #(
   parameter int FITNESS_BITS = tas_pkg::FITNESS_BITS_DEF
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_valid,
   output logic                          req_stall,
   input  logic [tas_pkg::IndexW-1:0]    req_contestant_index,
   input  logic [tas_pkg::FitInW-1:0]    req_contestant_fitness,
   output logic                          rsp_valid,
   input  logic                          rsp_stall,
   output logic                          rsp_accepted,
   output logic                          rsp_done_res,
   output logic [tas_pkg::IndexW-1:0]    rsp_parent_a_index,
   output logic [tas_pkg::IndexW-1:0]    rsp_parent_b_index,
   output logic [tas_pkg::IndexW-1:0]    rsp_child_a_index,
   output logic [tas_pkg::IndexW-1:0]    rsp_child_b_index,
   input  logic                          csr_wr_en,
   input  logic [tas_pkg::CountW-1:0]    csr_wr_data
);
   import tas_pkg::*;

   logic                 stage_valid_ff;
   logic                 stage_valid_in;
   logic [IndexW-1:0]    stage_index_ff;
   logic [FitInW-1:0]    stage_fitness_ff;
   logic                 rsp_valid_ff;
   logic                 rsp_valid_in;
   tas_result_type       rsp_result_ff;
   tas_result_type       rsp_result_in;
   logic [CountW-1:0]    rounds_ff;
   logic                 out_ready;
   logic                 fire;
   logic                 load;
   tas_result_type       arena_result;

   tas_arena #(
      .FITNESS_BITS(FITNESS_BITS)
   ) u_arena (
      .clock   (clock),
      .reset   (reset),
      .fire    (fire),
      .idx     (stage_index_ff),
      .fitness (stage_fitness_ff),
      .rounds  (rounds_ff),
      .result  (arena_result)
   );

   always_comb begin
      out_ready = !rsp_valid_ff || !rsp_stall;
      fire = stage_valid_ff && out_ready;
      req_stall = stage_valid_ff && !out_ready;
      load = req_valid && !req_stall;
      stage_valid_in = req_stall ? 1'b1 : req_valid;
      rsp_valid_in = out_ready ? fire : 1'b1;
      rsp_result_in = fire ? arena_result : rsp_result_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         stage_valid_ff <= 1'b0;
         rsp_valid_ff <= 1'b0;
         rounds_ff <= RoundsReset;
      end else begin
         stage_valid_ff <= stage_valid_in;
         rsp_valid_ff <= rsp_valid_in;
         if (csr_wr_en) begin
            rounds_ff <= csr_wr_data;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         stage_index_ff <= req_contestant_index;
         stage_fitness_ff <= req_contestant_fitness;
      end
      rsp_result_ff <= rsp_result_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_accepted = rsp_result_ff.accepted;
   assign rsp_done_res = rsp_result_ff.done_res;
   assign rsp_parent_a_index = rsp_result_ff.parent_a_index;
   assign rsp_parent_b_index = rsp_result_ff.parent_b_index;
   assign rsp_child_a_index = rsp_result_ff.child_a_index;
   assign rsp_child_b_index = rsp_result_ff.child_b_index;

endmodule
